FILE: rtl/pbt_pkg.sv
`default_nettype none

package pbt_pkg;

    // Width of the slot field in a result
    localparam int SLOT_W = 3;

    // Request operations
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_RECORD = 1'b1
    } opcode_t;

    // One binding: two-word serial number and four context words
    typedef struct packed {
        logic [31:0] serial_high;
        logic [31:0] serial_low;
        logic [31:0] region_start;
        logic [31:0] region_size;
        logic [31:0] globals_base;
        logic [31:0] stack_bottom;
    } binding_t;

    // Compare flags for one stored entry against the request
    typedef struct packed {
        logic full;    // all six words equal
        logic serial;  // serial number equal
        logic empty;   // stored serial number is all zeros
    } match_t;

endpackage

`default_nettype wire

FILE: rtl/pbt_mem.sv
`default_nettype none

module pbt_mem #(
    parameter int ENTRIES = 8,
    parameter int IDX_W   = 3
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  rd_en,
    input  wire [IDX_W-1:0]      rd_addr,
    output pbt_pkg::binding_t    rd_data,
    input  wire                  wr_en,
    input  wire [IDX_W-1:0]      wr_addr,
    input  pbt_pkg::binding_t    wr_data
);
    import pbt_pkg::*;

    binding_t             mem [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    binding_t             rd_data_reg;
    logic                 rd_live_reg;

    // Write port of the binding array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track written entries; reset empties the whole table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_live_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Never-written entries read as empty bindings
    assign rd_data = rd_live_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/pbt_match.sv
`default_nettype none

module pbt_match (
    input  pbt_pkg::binding_t entry,
    input  pbt_pkg::binding_t request,
    output pbt_pkg::match_t   flags
);
    import pbt_pkg::*;

    logic serial_eq;
    logic context_eq;

    // Compare serial number and context words separately
    assign serial_eq  = (entry.serial_high == request.serial_high)
                     && (entry.serial_low  == request.serial_low);
    assign context_eq = (entry.region_start == request.region_start)
                     && (entry.region_size  == request.region_size)
                     && (entry.globals_base == request.globals_base)
                     && (entry.stack_bottom == request.stack_bottom);

    assign flags.full   = serial_eq && context_eq;
    assign flags.serial = serial_eq;
    assign flags.empty  = (entry.serial_high == 32'd0) && (entry.serial_low == 32'd0);

endmodule

`default_nettype wire

FILE: rtl/process_binding_table.sv
// Process binding table: ENTRIES fully associative bindings (serial number plus four
// context words) held in a single-port-read memory. One transaction is worked at a time.
// A request with an all-zero serial number is refused without walking the table.
// Otherwise the table is walked one entry per cycle through the memory read port:
// a lookup answers at the first full match or after the last entry; a record walks
// until it finds its serial number or reaches the last entry, then writes. A new
// transaction is taken as soon as the previous result is in the output register,
// even if that result has not yet been taken. The table is empty right after reset;
// no clearing pass runs.
`default_nettype none

module process_binding_table #(
    parameter int ENTRIES = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         opcode,
    input  wire [31:0]  serial_high,
    input  wire [31:0]  serial_low,
    input  wire [31:0]  region_start,
    input  wire [31:0]  region_size,
    input  wire [31:0]  globals_base,
    input  wire [31:0]  stack_bottom,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        hit,
    output logic        refused,
    output logic [pbt_pkg::SLOT_W-1:0] slot
);
    import pbt_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDE_W = IDX_W + SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

    state_t               state_reg,       state_next;
    opcode_t              op_reg,          op_next;
    binding_t             req_reg,         req_next;
    logic [IDX_W-1:0]     issue_idx_reg,   issue_idx_next;
    logic                 issue_more_reg,  issue_more_next;
    logic [IDX_W-1:0]     chk_idx_reg,     chk_idx_next;
    logic                 chk_live_reg,    chk_live_next;
    logic                 have_empty_reg,  have_empty_next;
    logic [IDX_W-1:0]     empty_idx_reg,   empty_idx_next;
    logic [IDX_W-1:0]     target_reg,      target_next;
    logic [IDX_W-1:0]     rptr_reg,        rptr_next;
    logic                 res_hit_reg,     res_hit_next;
    logic                 res_refused_reg, res_refused_next;
    logic [IDX_W-1:0]     res_idx_reg,     res_idx_next;
    logic                 out_valid_reg,   out_valid_next;
    logic                 hit_reg,         hit_next;
    logic                 refused_reg,     refused_next;
    logic [SLOT_W-1:0]    slot_reg,        slot_next;

    binding_t             in_binding;
    binding_t             rd_data;
    match_t               flags;
    logic                 rd_en;
    logic                 wr_en;
    logic                 in_take;
    logic                 out_free;
    logic [WIDE_W-1:0]    res_idx_wide;

    assign in_binding.serial_high  = serial_high;
    assign in_binding.serial_low   = serial_low;
    assign in_binding.region_start = region_start;
    assign in_binding.region_size  = region_size;
    assign in_binding.globals_base = globals_base;
    assign in_binding.stack_bottom = stack_bottom;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_en    = (state_reg == ST_SCAN) && issue_more_reg;
    assign wr_en    = (state_reg == ST_WRITE);

    // Slot reports the entry index modulo eight
    assign res_idx_wide = WIDE_W'(res_idx_reg);

    pbt_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (target_reg),
        .wr_data (req_reg)
    );

    pbt_match u_match (
        .entry   (rd_data),
        .request (req_reg),
        .flags   (flags)
    );

    // Sequence accept, table walk, write-back and result hand-off
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        req_next         = req_reg;
        issue_idx_next   = issue_idx_reg;
        issue_more_next  = issue_more_reg;
        chk_idx_next     = chk_idx_reg;
        chk_live_next    = chk_live_reg;
        have_empty_next  = have_empty_reg;
        empty_idx_next   = empty_idx_reg;
        target_next      = target_reg;
        rptr_next        = rptr_reg;
        res_hit_next     = res_hit_reg;
        res_refused_next = res_refused_reg;
        res_idx_next     = res_idx_reg;
        out_valid_next   = out_valid_reg;
        hit_next         = hit_reg;
        refused_next     = refused_reg;
        slot_next        = slot_reg;

        // Drop the output transaction once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    op_next         = opcode_t'(opcode);
                    req_next        = in_binding;
                    issue_idx_next  = '0;
                    issue_more_next = 1'b1;
                    chk_live_next   = 1'b0;
                    have_empty_next = 1'b0;
                    empty_idx_next  = '0;
                    res_hit_next    = 1'b0;
                    res_idx_next    = '0;
                    if ((serial_high == 32'd0) && (serial_low == 32'd0))
                    begin
                        res_refused_next = 1'b1;
                        state_next       = ST_RESP;
                    end
                    else
                    begin
                        res_refused_next = 1'b0;
                        state_next       = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Advance the read address one entry per cycle
                chk_live_next = rd_en;
                chk_idx_next  = issue_idx_reg;
                if (rd_en)
                begin
                    issue_idx_next  = issue_idx_reg + 1'b1;
                    issue_more_next = (issue_idx_reg != LAST_IDX);
                end

                // Check the entry whose data has just arrived
                if (chk_live_reg)
                begin
                    unique case (op_reg)
                        OP_LOOKUP:
                        begin
                            if (flags.full)
                            begin
                                res_hit_next = 1'b1;
                                res_idx_next = chk_idx_reg;
                                state_next   = ST_RESP;
                            end
                            else if (chk_idx_reg == LAST_IDX)
                            begin
                                state_next = ST_RESP;
                            end
                        end

                        OP_RECORD:
                        begin
                            if (flags.serial)
                            begin
                                target_next = chk_idx_reg;
                                state_next  = ST_WRITE;
                            end
                            else
                            begin
                                if (flags.empty && !have_empty_reg)
                                begin
                                    have_empty_next = 1'b1;
                                    empty_idx_next  = chk_idx_reg;
                                end
                                if (chk_idx_reg == LAST_IDX)
                                begin
                                    state_next = ST_WRITE;
                                    if (have_empty_reg)
                                    begin
                                        target_next = empty_idx_reg;
                                    end
                                    else if (flags.empty)
                                    begin
                                        target_next = chk_idx_reg;
                                    end
                                    else
                                    begin
                                        // Evict under the round-robin pointer
                                        target_next = rptr_reg;
                                        rptr_next   = (rptr_reg == LAST_IDX) ? '0
                                                                             : rptr_reg + 1'b1;
                                    end
                                end
                            end
                        end

                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_WRITE:
            begin
                res_idx_next = target_reg;
                state_next   = ST_RESP;
            end

            ST_RESP:
            begin
                // Hold the result until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    refused_next   = res_refused_reg;
                    slot_next      = res_idx_wide[SLOT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_LOOKUP;
            req_reg         <= '0;
            issue_idx_reg   <= '0;
            issue_more_reg  <= 1'b0;
            chk_idx_reg     <= '0;
            chk_live_reg    <= 1'b0;
            have_empty_reg  <= 1'b0;
            empty_idx_reg   <= '0;
            target_reg      <= '0;
            rptr_reg        <= '0;
            res_hit_reg     <= 1'b0;
            res_refused_reg <= 1'b0;
            res_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            refused_reg     <= 1'b0;
            slot_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            req_reg         <= req_next;
            issue_idx_reg   <= issue_idx_next;
            issue_more_reg  <= issue_more_next;
            chk_idx_reg     <= chk_idx_next;
            chk_live_reg    <= chk_live_next;
            have_empty_reg  <= have_empty_next;
            empty_idx_reg   <= empty_idx_next;
            target_reg      <= target_next;
            rptr_reg        <= rptr_next;
            res_hit_reg     <= res_hit_next;
            res_refused_reg <= res_refused_next;
            res_idx_reg     <= res_idx_next;
            out_valid_reg   <= out_valid_next;
            hit_reg         <= hit_next;
            refused_reg     <= refused_next;
            slot_reg        <= slot_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign refused   = refused_reg;
    assign slot      = slot_reg;

endmodule

`default_nettype wire

FILE: verif/binding_table_checker.sv
module binding_table_checker #(
    parameter int ENTRIES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  pbt_pkg::opcode_t            opcode,
    input  logic [31:0]                 serial_high,
    input  logic [31:0]                 serial_low,
    input  logic [31:0]                 region_start,
    input  logic [31:0]                 region_size,
    input  logic [31:0]                 globals_base,
    input  logic [31:0]                 stack_bottom,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        hit,
    input  logic                        refused,
    input  logic [pbt_pkg::SLOT_W-1:0]  slot,
    output int                          errors,
    output int                          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import pbt_pkg::*;

    typedef struct packed {
        logic              hit;
        logic              refused;
        logic [SLOT_W-1:0] slot;
    } answer_t;

    // Shadow copy of the table and its victim pointer
    binding_t    bindings [ENTRIES];
    int unsigned victim;
    answer_t     answer_q [$];
    answer_t     want;

    // Apply one request to the shadow table and return the answer it should get
    function automatic answer_t apply_request(input opcode_t op, input binding_t req);
        answer_t a;
        int      target;
        int      empty_at;
        a        = '0;
        target   = -1;
        empty_at = -1;
        if (req.serial_high == '0 && req.serial_low == '0)
        begin
            a.refused = 1'b1;
        end
        else if (op == OP_LOOKUP)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (target < 0 && bindings[i] == req)
                    target = i;
            end
            if (target >= 0)
            begin
                a.hit  = 1'b1;
                a.slot = SLOT_W'(target);
            end
        end
        else
        begin
            // same serial wins over the first empty entry, which wins over eviction
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (target < 0)
                begin
                    if (bindings[i].serial_high == req.serial_high &&
                        bindings[i].serial_low == req.serial_low)
                        target = i;
                    else if (empty_at < 0 && bindings[i].serial_high == '0 &&
                             bindings[i].serial_low == '0)
                        empty_at = i;
                end
            end
            if (target < 0)
                target = empty_at;
            if (target < 0)
            begin
                target = int'(victim);
                victim = (victim + 1) % ENTRIES;
            end
            bindings[target] = req;
            a.slot           = SLOT_W'(target);
        end
        return a;
    endfunction

    // Compare each result transaction, then predict each request transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                bindings[i] = '0;
            end
            victim = 0;
            answer_q.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    errors++;
                    $error("result with none expected: hit=%0d refused=%0d slot=%0d",
                           hit, refused, slot);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (hit !== want.hit)
                    begin
                        errors++;
                        $error("hit: expected %0d, actual %0d", want.hit, hit);
                    end
                    if (refused !== want.refused)
                    begin
                        errors++;
                        $error("refused: expected %0d, actual %0d", want.refused, refused);
                    end
                    if (slot !== want.slot)
                    begin
                        errors++;
                        $error("slot: expected %0d, actual %0d", want.slot, slot);
                    end
                end
            end
            if (in_valid && !in_stall)
                answer_q.push_back(apply_request(opcode, {serial_high, serial_low,
                    region_start, region_size, globals_base, stack_bottom}));
            pending = answer_q.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pbt_pkg::*;

    localparam int ENTRIES      = 8;
    localparam int POOL         = 12;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    opcode_t           opcode;
    logic [31:0]       serial_high;
    logic [31:0]       serial_low;
    logic [31:0]       region_start;
    logic [31:0]       region_size;
    logic [31:0]       globals_base;
    logic [31:0]       stack_bottom;
    logic              out_valid;
    logic              out_stall;
    logic              hit;
    logic              refused;
    logic [SLOT_W-1:0] slot;
    int                errors;
    int                pending;
    int                cycles = 0;
    int                hold_asks = 0;
    bit                quiet = 1'b0;
    binding_t          known [POOL];

    process_binding_table #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .serial_high(serial_high),
        .serial_low(serial_low),
        .region_start(region_start),
        .region_size(region_size),
        .globals_base(globals_base),
        .stack_bottom(stack_bottom),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .refused(refused),
        .slot(slot)
    );

    binding_table_checker #(
        .ENTRIES(ENTRIES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .serial_high(serial_high),
        .serial_low(serial_low),
        .region_start(region_start),
        .region_size(region_size),
        .globals_base(globals_base),
        .stack_bottom(stack_bottom),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .refused(refused),
        .slot(slot),
        .errors(errors),
        .pending(pending)
    );

    // Clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        int seen;
        seen      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != seen)
            begin
                seen = hold_asks;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 14);
        end
    end

    function automatic binding_t make_binding(input logic [31:0] sh, input logic [31:0] sl,
                                              input logic [31:0] rs, input logic [31:0] rz,
                                              input logic [31:0] gb, input logic [31:0] sb);
        return '{sh, sl, rs, rz, gb, sb};
    endfunction

    // Random binding with a nonzero serial; the upper word is often zero
    function automatic binding_t rand_binding();
        binding_t b;
        b = make_binding($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 99) < 30)
            b.serial_high = '0;
        if (b.serial_high == '0 && b.serial_low == '0)
            b.serial_low = 32'd1;
        return b;
    endfunction

    // Offer one transaction at a falling edge and hold it until accepted
    task automatic send(input opcode_t op, input binding_t b);
        while (!quiet && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        serial_high  <= b.serial_high;
        serial_low   <= b.serial_low;
        region_start <= b.region_start;
        region_size  <= b.region_size;
        globals_base <= b.globals_base;
        stack_bottom <= b.stack_bottom;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Mostly lookups and records over a small pool of live processes
    task automatic random_item();
        int       k;
        int       pick;
        binding_t b;
        opcode_t  op;
        k    = $urandom_range(0, POOL - 1);
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            b             = rand_binding();
            b.serial_high = '0;
            b.serial_low  = '0;
            op            = opcode_t'($urandom_range(0, 1));
        end
        else if (pick < 52)
        begin
            op = OP_RECORD;
            if ($urandom_range(0, 99) < 25)
                known[k] = rand_binding();
            else if ($urandom_range(0, 99) < 40)
            begin
                known[k].region_start = $urandom;
                known[k].globals_base = $urandom;
            end
            b = known[k];
        end
        else
        begin
            op   = OP_LOOKUP;
            b    = known[k];
            pick = $urandom_range(0, 99);
            if (pick < 20)
                b = b ^ (192'(1) << $urandom_range(0, 191));
            else if (pick < 30)
                b = rand_binding();
        end
        send(op, b);
    endtask

    // Stimulus and verdict
    initial
    begin
        in_valid     = 1'b0;
        opcode       = OP_LOOKUP;
        serial_high  = '0;
        serial_low   = '0;
        region_start = '0;
        region_size  = '0;
        globals_base = '0;
        stack_bottom = '0;
        rst_n        = 1'b0;
        for (int i = 0; i < POOL; i++)
        begin
            known[i] = rand_binding();
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, refusals in both operations, extremes of every field
        send(OP_LOOKUP, make_binding(1, 2, 3, 4, 5, 6));
        send(OP_LOOKUP, make_binding(0, 0, 0, 0, 0, 0));
        send(OP_RECORD, make_binding(0, 0, '1, '1, '1, '1));
        send(OP_RECORD, make_binding('1, '1, '1, '1, '1, '1));
        send(OP_LOOKUP, make_binding('1, '1, '1, '1, '1, '1));
        send(OP_LOOKUP, make_binding('1, '1, '1, '1, '1, 32'hFFFF_FFFE));
        send(OP_RECORD, make_binding(0, 1, 0, 0, 0, 0));
        send(OP_RECORD, make_binding(1, 0, 32'h8000_0000, 32'h8000_0000, 1, 1));
        send(OP_LOOKUP, make_binding(0, 1, 0, 0, 0, 0));

        // Overwrite the entry holding the same serial while empties remain
        send(OP_RECORD, make_binding('1, '1, 1, 2, 3, 4));
        send(OP_LOOKUP, make_binding('1, '1, '1, '1, '1, '1));
        send(OP_LOOKUP, make_binding('1, '1, 1, 2, 3, 4));

        // Fill the table, then evict round-robin
        for (int k = 3; k < ENTRIES; k++)
        begin
            send(OP_RECORD, make_binding(32'h100 + k, k, 32'h1000 * k, 32'h400, k, ~k));
        end
        send(OP_RECORD, make_binding(32'hDEAD, 1, 5, 6, 7, 8));
        send(OP_RECORD, make_binding(32'hDEAD, 2, 5, 6, 7, 8));
        send(OP_LOOKUP, make_binding(32'h107, 7, 32'h7000, 32'h400, 7, ~32'd7));
        send(OP_LOOKUP, make_binding('1, '1, 1, 2, 3, 4));
        send(OP_RECORD, make_binding(32'h105, 5, 9, 9, 9, 9));
        send(OP_LOOKUP, make_binding(32'h105, 5, 9, 9, 9, 9));

        // Random traffic with idling on both sides
        repeat (170) random_item();

        // No idling; hold off the result side so the block backs up
        quiet     <= 1'b1;
        hold_asks <= hold_asks + 1;
        repeat (110) random_item();
        quiet    <= 1'b0;

        // Pause until every result has come back
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        repeat (270) random_item();

        // Drain and give the verdict
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: process_binding_table.f
rtl/pbt_pkg.sv
rtl/pbt_mem.sv
rtl/pbt_match.sv
rtl/process_binding_table.sv
verif/binding_table_checker.sv
verif/tb_top.sv
